// ===== rtl/trsr_pkg.sv =====
// ---------------------------------------------------------------------------
// trsr_pkg: shared types and constants of the text row scanline renderer
// Action codes, register indexes, sequencer states and font port bundles.
// ---------------------------------------------------------------------------
package trsr_pkg;

   localparam int CELLS_PER_LINE_DEF = 32;
   localparam int FONT_ADDR_BITS_DEF = 13;

   // register indexes on the csr port
   localparam logic CSR_FONT_PAGE   = 1'b0;
   localparam logic CSR_FRAME_LINES = 1'b1;

   localparam logic [9:0] FRAME_LINES_RST = 10'd310;
   localparam logic [7:0] ROW_CNT_TOP     = 8'd32;   // row counter value that forces line 0
   localparam logic [7:0] INV_MASK        = 8'hff;
   localparam logic [5:0] CHAR_MASK       = 6'h3f;

   // word kind, carried on req_tuser
   localparam logic [1:0] ACT_DISPLAY  = 2'd0;
   localparam logic [1:0] ACT_ROW_END  = 2'd1;
   localparam logic [1:0] ACT_FONT_WR  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CODE,
      S_FONT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic        en;
      logic [12:0] addr;
      logic [7:0]  data;
   } font_wr_type;

   typedef struct packed {
      logic       en;
      logic [7:0] code;
      logic [2:0] row;
   } font_rd_type;

endpackage

// ===== rtl/text_row_scanline_renderer.sv =====
// ---------------------------------------------------------------------------
// text_row_scanline_renderer: text-mode scanline generator
// Display and font words are accepted back to back while the sequencer is idle.
// A row-end word emits CELLS_PER_LINE words; each cell goes through code read,
// font read and output load, and the load waits while the output slot is full.
// Input stalls meanwhile.
// Reset is synchronous: control, counters and config registers clear; the
// output payload is not reset; font store contents stay undefined until written; no clearing pass.
// ---------------------------------------------------------------------------
module text_row_scanline_renderer
   import trsr_pkg::*;
#(
   parameter int CELLS_PER_LINE = CELLS_PER_LINE_DEF,
   parameter int FONT_ADDR_BITS = FONT_ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] code, [15:8] row_counter, [28:16] font_addr, [36:29] font_byte
   input  logic [39:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [8:0] line_number, [13:9] cell_column, [21:14] pixel_bits
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int CELL_W = (CELLS_PER_LINE > 1) ? $clog2(CELLS_PER_LINE) : 1;
   localparam int FILL_W = $clog2(CELLS_PER_LINE + 1);

   // input word fields
   logic [1:0]  action;
   logic [7:0]  in_code;
   logic [7:0]  in_row_counter;
   logic [12:0] in_font_addr;
   logic [7:0]  in_font_byte;

   assign action         = req_tuser;
   assign in_code        = req_tdata[7:0];
   assign in_row_counter = req_tdata[15:8];
   assign in_font_addr   = req_tdata[28:16];
   assign in_font_byte   = req_tdata[36:29];

   // state
   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [8:0]         line_ff, line_in;
   logic [2:0]         grow_ff, grow_in;     // glyph row of the line being drawn
   logic [7:0]         page_ff;
   logic [9:0]         lines_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [21:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_acc;
   logic               slot_free;
   logic               last_cell;
   logic               in_row;
   logic [9:0]         line_inc;

   // code buffer port
   logic               code_we;
   logic               code_re;
   logic [7:0]         code_q;

   font_wr_type        font_wr;
   font_rd_type        font_rd;
   logic [7:0]         pixel_bits;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign last_cell  = (cell_ff == CELL_W'(CELLS_PER_LINE - 1));
   // cells past the fill count show code 0
   assign in_row     = (FILL_W'(cell_ff) < fill_ff);
   assign line_inc   = {1'b0, line_ff} + 10'd1;

   // ---- display code buffer ----
   assign code_we = req_acc && (action == ACT_DISPLAY)
                 && (fill_ff < FILL_W'(CELLS_PER_LINE));
   assign code_re = (state_ff == S_CODE);

   trsr_ram #(
      .WIDTH (8),
      .DEPTH (CELLS_PER_LINE),
      .AW    (CELL_W)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (fill_ff[CELL_W-1:0]),
      .wr_data (in_code),
      .rd_en   (code_re),
      .rd_addr (cell_ff),
      .rd_data (code_q)
   );

   // ---- font store and lookup ----
   always_comb begin
      font_wr.en   = req_acc && (action == ACT_FONT_WR);
      font_wr.addr = in_font_addr;
      font_wr.data = in_font_byte;
      font_rd.en   = (state_ff == S_FONT);
      font_rd.code = in_row ? code_q : 8'h00;
      font_rd.row  = grow_ff;
   end

   trsr_glyph_unit #(
      .FONT_ADDR_BITS (FONT_ADDR_BITS)
   ) u_glyph (
      .clock      (clock),
      .font_page  (page_ff),
      .wr         (font_wr),
      .rd         (font_rd),
      .pixel_bits (pixel_bits)
   );

   // ---- sequencer: next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (action == ACT_ROW_END)) begin
               state_in = S_CODE;
            end
         end
         S_CODE: state_in = S_FONT;
         S_FONT: state_in = S_EMIT;
         S_EMIT: begin
            if (slot_free) begin
               state_in = last_cell ? S_IDLE : S_CODE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---- sequencer: datapath updates ----
   always_comb begin
      cell_in      = cell_ff;
      fill_in      = fill_ff;
      line_in      = line_ff;
      grow_in      = grow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (code_we) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (req_acc && (action == ACT_ROW_END)) begin
               // advance scanline; wrap on frame height, row counter 32 or overflow
               if ((line_inc == lines_ff) || (in_row_counter == ROW_CNT_TOP)
                   || line_inc[9]) begin
                  line_in = 9'd0;
               end else begin
                  line_in = line_inc[8:0];
               end
               // (8 - row_counter) mod 8
               grow_in = 3'(4'd8 - {1'b0, in_row_counter[2:0]});
               cell_in = '0;
            end
         end
         S_CODE: ;
         S_FONT: ;
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pixel_bits, 5'(cell_ff), line_ff};
               rsp_last_in  = last_cell;
               if (last_cell) begin
                  fill_in = '0;
               end else begin
                  cell_in = cell_ff + CELL_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cell_ff      <= '0;
         fill_ff      <= '0;
         line_ff      <= '0;
         grow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         page_ff      <= 8'h00;
         lines_ff     <= FRAME_LINES_RST;
      end else begin
         state_ff     <= state_in;
         cell_ff      <= cell_in;
         fill_ff      <= fill_in;
         line_ff      <= line_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FONT_PAGE:   page_ff  <= csr_wdata[7:0];
               CSR_FRAME_LINES: lines_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // output word register, payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CELLS_PER_LINE))
      else $error("fill count past line length");

   a_row_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (action == ACT_ROW_END)) |=> (state_ff == S_CODE) && (cell_ff == '0))
      else $error("row end did not start at cell 0");

   a_row_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && slot_free && last_cell)
      |=> (state_ff == S_IDLE) && (fill_ff == '0) && rsp_valid_ff && rsp_last_ff)
      else $error("row did not close cleanly");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      code_we |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("display word not counted");
`endif

endmodule

// ===== rtl/trsr_ram.sv =====
// ---------------------------------------------------------------------------
// trsr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module trsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/trsr_glyph_unit.sv =====
// ---------------------------------------------------------------------------
// trsr_glyph_unit: font store and glyph lookup
// Builds the font address from page, character and glyph row, reads the
// store and applies inverse video on the way out.
// ---------------------------------------------------------------------------
module trsr_glyph_unit
   import trsr_pkg::*;
#(
   parameter int FONT_ADDR_BITS = FONT_ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic [7:0]  font_page,
   input  font_wr_type wr,
   input  font_rd_type rd,
   output logic [7:0]  pixel_bits
);

   localparam int DEPTH = 1 << FONT_ADDR_BITS;

   logic [15:0]               rd_addr_full;
   logic [FONT_ADDR_BITS-1:0] rd_addr;
   logic [FONT_ADDR_BITS-1:0] wr_addr;
   logic [7:0]                glyph;
   logic                      inv_ff;

   // page overlaps the top character bit, so this is an OR, not a concat
   assign rd_addr_full = {font_page, 8'h00}
                       | {7'd0, rd.code[5:0] & CHAR_MASK, 3'd0}
                       | {13'd0, rd.row};
   assign rd_addr = FONT_ADDR_BITS'(rd_addr_full);
   assign wr_addr = FONT_ADDR_BITS'(wr.addr);

   trsr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH),
      .AW    (FONT_ADDR_BITS)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd_addr),
      .rd_data (glyph)
   );

   always_ff @(posedge clock) begin
      if (rd.en) begin
         inv_ff <= rd.code[7];
      end
   end

   assign pixel_bits = glyph ^ (inv_ff ? INV_MASK : 8'h00);

endmodule
